### sv/hhfc_pkg.sv
// package: commands, beat types and match tables for the header framing checker
package hhfc_pkg;

  typedef enum logic [2:0] {
    CMD_NAME  = 3'd0,
    CMD_VALUE = 3'd1,
    CMD_FIELD = 3'd2,
    CMD_BLOCK = 3'd3,
    CMD_NEW   = 3'd4
  } cmd_e;

  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_CL    = 3'd1;
  localparam logic [2:0] KIND_TE    = 3'd2;
  localparam logic [2:0] KIND_CONN  = 3'd3;
  localparam logic [2:0] KIND_UPG   = 3'd4;

  localparam logic [1:0] FRM_NONE    = 2'd0;
  localparam logic [1:0] FRM_CHUNKED = 2'd1;
  localparam logic [1:0] FRM_LENGTH  = 2'd2;
  localparam logic [1:0] FRM_CLOSE   = 2'd3;

  localparam logic [63:0] LEN_LIMIT = 64'd1844674407370955161;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic        block_end;
    logic [2:0]  field_kind;
    logic        error_flag;
    logic [1:0]  framing;
    logic [63:0] body_length;
    logic        close_connection;
    logic        websocket_upgrade;
  } out_beat_t;

  // per-field value summary handed from the byte tracker to the message logic
  typedef struct packed {
    logic [2:0]  kind;
    logic        len_ok;
    logic [63:0] len_value;
    logic        te_ok;
    logic        flag_close;
    logic        flag_keep;
    logic        flag_ws;
  } field_sum_t;

  localparam int NAME_LEN [4] = '{14, 17, 10, 7};
  localparam int TOK_LEN  [4] = '{7, 5, 10, 9};

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // expected name character, zero past the end; first char in highest used byte
  function automatic logic [7:0] name_char(input int i, input logic [4:0] p);
    logic [8*17-1:0] s;
    case (i)
      0: s = {24'h0, "content-length"};
      1: s = "transfer-encoding";
      2: s = {56'h0, "connection"};
      default: s = {80'h0, "upgrade"};
    endcase
    name_char = (int'(p) < NAME_LEN[i]) ? s[8*(NAME_LEN[i]-1-int'(p)) +: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] tok_char(input int i, input logic [3:0] p);
    logic [8*10-1:0] s;
    case (i)
      0: s = {24'h0, "chunked"};
      1: s = {40'h0, "close"};
      2: s = "keep-alive";
      default: s = {8'h0, "websocket"};
    endcase
    tok_char = (int'(p) < TOK_LEN[i]) ? s[8*(TOK_LEN[i]-1-int'(p)) +: 8] : 8'h00;
  endfunction

endpackage

### sv/http_header_framing_checker.sv
// top level of the http header framing checker
// Byte-level checker for HTTP/1.1 body framing.
// Input channel (in_valid/in_ready/in_data) carries one beat per header byte
// or command: name byte, value byte, end of field, end of header block or
// new message. Output channel (out_valid/out_ready/out_data) carries one
// result beat for each end of field and each end of header block; other
// commands produce no beat.
// The incoming beat is registered, evaluated by the field tracker and
// message logic in one pass, and its result is written to the output
// register. One beat per cycle is sustained unless a held result stalls
// it; the input register and the output register are the two stages.
// The user writes response_mode via cfg_we/cfg_data only while idle; the
// block has no check for it. Reset clears all field and message state and
// the mode register. While the receiver stalls, a held result keeps in_ready
// low only if a new result must replace it; the staged beat waits in place.
module http_header_framing_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hhfc_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hhfc_pkg::out_beat_t  out_data
);
  import hhfc_pkg::*;

  logic       resp;
  logic       stg_valid;
  in_beat_t   stg;
  logic       fire, res_en, stg_ready;
  field_sum_t sum;
  out_beat_t  res;

  // staged beat is processed once the output can take any result it makes
  assign stg_ready = !res_en || !out_valid || out_ready;
  assign fire      = stg_valid && stg_ready;
  assign in_ready  = !stg_valid || stg_ready;

  always_ff @(posedge clk) begin
    if (rst) resp <= 1'b0;
    else if (cfg_we) resp <= cfg_data;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) stg_valid <= 1'b0;
    else if (in_ready) stg_valid <= in_valid;
    if (in_ready && in_valid) stg <= in_data;
  end

  hhfc_field u_field (.clk(clk), .rst(rst), .fire(fire), .beat(stg), .sum(sum));

  hhfc_msg u_msg (
    .clk(clk), .rst(rst), .fire(fire), .resp(resp), .cmd(stg.cmd),
    .sum(sum), .res(res), .res_en(res_en)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (fire && res_en) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (fire && res_en) out_data <= res;
  end
endmodule

### sv/hhfc_field.sv
// field tracker: name match, length digits and token lists
module hhfc_field (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  hhfc_pkg::in_beat_t  beat,
  output hhfc_pkg::field_sum_t sum
);
  import hhfc_pkg::*;

  logic [4:0]  name_pos, name_pos_next;
  logic [3:0]  name_cand, name_cand_next;
  logic [1:0]  phase, phase_next;
  logic [63:0] accum, accum_next;
  logic        len_bad, len_bad_next;
  logic [3:0]  tok_pos, tok_pos_next;
  logic [3:0]  tok_cand, tok_cand_next;
  logic [2:0]  part, part_next;
  logic [3:0]  fflags, fflags_next;
  logic [3:0]  last;
  logic [7:0]  lc;
  logic        clear;

  assign lc = to_lower(beat.data_byte);

  // matches of the current token part
  always_comb begin
    last = '0;
    for (int i = 0; i < 4; i++) begin
      if (part[0] && tok_cand[i] && int'(tok_pos) == TOK_LEN[i]) last[i] = 1'b1;
    end
  end

  // field summary seen at end of field
  always_comb begin
    logic [3:0] f;
    sum.kind = KIND_OTHER;
    for (int i = 3; i >= 0; i--) begin
      if (name_cand[i] && int'(name_pos) == NAME_LEN[i]) sum.kind = 3'(i + 1);
    end
    f = fflags | {last[3:1], 1'b0};
    sum.len_ok     = !len_bad && phase != 2'd0;
    sum.len_value  = accum;
    sum.te_ok      = !fflags[0] && last[0];
    sum.flag_close = f[1];
    sum.flag_keep  = f[2];
    sum.flag_ws    = f[3];
  end

  // per-byte next state
  always_comb begin
    logic ws, dig;
    logic [63:0] d;
    ws = is_ws(beat.data_byte);
    dig = beat.data_byte >= 8'h30 && beat.data_byte <= 8'h39;
    d = {60'd0, beat.data_byte[3:0]};
    name_pos_next = name_pos;  name_cand_next = name_cand;
    phase_next = phase;        accum_next = accum;  len_bad_next = len_bad;
    tok_pos_next = tok_pos;    tok_cand_next = tok_cand;
    part_next = part;          fflags_next = fflags;
    clear = 1'b0;
    case (beat.cmd)
      CMD_NAME: begin
        for (int i = 0; i < 4; i++) begin
          if (name_char(i, name_pos) != lc || int'(name_pos) >= NAME_LEN[i])
            name_cand_next[i] = 1'b0;
        end
        if (name_pos != 5'd31) name_pos_next = name_pos + 5'd1;
      end
      CMD_VALUE: begin
        // decimal length
        if (phase == 2'd2) begin
          if (!ws) len_bad_next = 1'b1;
        end else if (dig) begin
          if (accum > LEN_LIMIT || (accum == LEN_LIMIT && beat.data_byte[3:0] > 4'd5))
            len_bad_next = 1'b1;
          else
            accum_next = (accum << 3) + (accum << 1) + d;
          phase_next = 2'd1;
        end else if (ws) begin
          if (phase == 2'd1) phase_next = 2'd2;
        end else begin
          len_bad_next = 1'b1;
        end
        // token list
        if (beat.data_byte == 8'h2C) begin
          fflags_next = fflags | {last[3:1], 1'b1};
          tok_pos_next = '0; tok_cand_next = '1; part_next = '0;
        end else if (part[2]) begin
        end else if (beat.data_byte == 8'h3B) begin
          part_next[2] = 1'b1;
        end else if (ws) begin
          if (part[0]) part_next[1] = 1'b1;
        end else begin
          tok_cand_next = part[1] ? 4'd0 : tok_cand;
          part_next[1] = 1'b0;
          part_next[0] = 1'b1;
          for (int i = 0; i < 4; i++) begin
            if (tok_char(i, tok_pos) != lc || int'(tok_pos) >= TOK_LEN[i])
              tok_cand_next[i] = 1'b0;
          end
          if (tok_pos != 4'd15) tok_pos_next = tok_pos + 4'd1;
        end
      end
      CMD_FIELD, CMD_BLOCK, CMD_NEW: clear = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && clear)) begin
      name_pos <= '0; name_cand <= '1; phase <= '0; accum <= '0; len_bad <= 1'b0;
      tok_pos <= '0; tok_cand <= '1; part <= '0; fflags <= '0;
    end else if (fire) begin
      name_pos <= name_pos_next; name_cand <= name_cand_next; phase <= phase_next;
      accum <= accum_next; len_bad <= len_bad_next; tok_pos <= tok_pos_next;
      tok_cand <= tok_cand_next; part <= part_next; fflags <= fflags_next;
    end
  end
endmodule

### sv/hhfc_msg.sv
// message state: framing headers, sticky error and result beat
module hhfc_msg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic                 resp,
  input  logic [2:0]           cmd,
  input  hhfc_pkg::field_sum_t sum,
  output hhfc_pkg::out_beat_t  res,
  output logic                 res_en
);
  import hhfc_pkg::*;

  logic        has_len, has_len_next, has_chk, has_chk_next;
  logic        err, err_next, cls, cls_next, wsk, wsk_next;
  logic [63:0] slen, slen_next;
  logic [1:0]  frm;

  always_comb begin
    has_len_next = has_len; has_chk_next = has_chk; err_next = err;
    cls_next = cls; wsk_next = wsk; slen_next = slen;
    frm = FRM_NONE; res_en = 1'b0;
    case (cmd)
      CMD_FIELD: begin
        res_en = 1'b1;
        case (sum.kind)
          KIND_CL: begin
            if (!sum.len_ok || (has_len && slen != sum.len_value) || (resp && has_chk))
              err_next = 1'b1;
            else begin
              slen_next = sum.len_value; has_len_next = 1'b1;
            end
          end
          KIND_TE: begin
            if (!sum.te_ok) err_next = 1'b1;
            else begin
              if (resp && has_len) err_next = 1'b1;
              has_chk_next = 1'b1;
            end
          end
          KIND_CONN: begin
            if (sum.flag_close) cls_next = 1'b1;
            else if (!resp && sum.flag_keep) cls_next = 1'b0;
          end
          KIND_UPG: if (!resp && sum.flag_ws) wsk_next = 1'b1;
          default: ;
        endcase
      end
      CMD_BLOCK: begin
        res_en = 1'b1;
        if (!resp && has_len && has_chk) begin
          err_next = 1'b1;
        end else if (has_chk) frm = FRM_CHUNKED;
        else if (has_len) frm = (slen != 64'd0) ? FRM_LENGTH : FRM_NONE;
        else frm = resp ? FRM_CLOSE : FRM_NONE;
      end
      CMD_NEW: begin
        has_len_next = 1'b0; has_chk_next = 1'b0; err_next = 1'b0;
        cls_next = 1'b0; wsk_next = 1'b0; slen_next = '0;
      end
      default: ;
    endcase
    res.block_end         = (cmd == CMD_BLOCK);
    res.field_kind        = (cmd == CMD_FIELD) ? sum.kind : KIND_OTHER;
    res.error_flag        = err_next;
    res.framing           = frm;
    res.body_length       = has_len_next ? slen_next : 64'd0;
    res.close_connection  = cls_next;
    res.websocket_upgrade = wsk_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_len <= 1'b0; has_chk <= 1'b0; err <= 1'b0; cls <= 1'b0; wsk <= 1'b0;
      slen <= '0;
    end else if (fire) begin
      has_len <= has_len_next; has_chk <= has_chk_next; err <= err_next;
      cls <= cls_next; wsk <= wsk_next; slen <= slen_next;
    end
  end
endmodule
